// ===== design/mfr_pkg.sv =====
// shared types and codes for the frame receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mfr_pkg;

    localparam logic [1:0] KIND_COMMAND = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_GOOD    = 2'd2;
    localparam logic [1:0] KIND_BAD     = 2'd3;

    localparam logic [1:0] CFG_HEADER_FIRST   = 2'd0;
    localparam logic [1:0] CFG_HEADER_SECOND  = 2'd1;
    localparam logic [1:0] CFG_DIRECTION_BYTE = 2'd2;

    localparam logic [7:0] RST_HEADER_FIRST   = 8'd36;
    localparam logic [7:0] RST_HEADER_SECOND  = 8'd77;
    localparam logic [7:0] RST_DIRECTION_BYTE = 8'd62;

    typedef struct packed {
        logic       frame_last;
        logic [7:0] payload_length;
        logic [7:0] frame_command;
        logic [7:0] data_byte;
        logic [1:0] kind;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } push_t;

endpackage

`default_nettype wire

// ===== design/mfr_parser.sv =====
// front end: header matching, length/command capture, running checksum
// depends on mfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mfr_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          cfg_write,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    output mfr_pkg::push_t     push
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_HDR2    = 3'd2;
    localparam logic [2:0] PH_DIR     = 3'd3;
    localparam logic [2:0] PH_LEN     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    logic [7:0] header_first_reg;
    logic [7:0] header_second_reg;
    logic [7:0] direction_byte_reg;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] expected_reg, expected_next;
    logic [7:0] taken_reg, taken_next;
    logic [7:0] command_reg, command_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg   <= mfr_pkg::RST_HEADER_FIRST;
            header_second_reg  <= mfr_pkg::RST_HEADER_SECOND;
            direction_byte_reg <= mfr_pkg::RST_DIRECTION_BYTE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mfr_pkg::CFG_HEADER_FIRST:   header_first_reg   <= cfg_data;
                mfr_pkg::CFG_HEADER_SECOND:  header_second_reg  <= cfg_data;
                mfr_pkg::CFG_DIRECTION_BYTE: direction_byte_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        xor_next      = xor_reg;
        expected_next = expected_reg;
        taken_next    = taken_reg;
        command_next  = command_reg;
        push.valid    = 1'b0;
        push.res.kind           = mfr_pkg::KIND_COMMAND;
        push.res.data_byte      = rx_byte;
        push.res.frame_command  = command_reg;
        push.res.payload_length = expected_reg;
        push.res.frame_last     = 1'b0;
        case (phase_reg)
            PH_HDR1:
            begin
                phase_next = (rx_byte == header_second_reg) ? PH_HDR2 : PH_IDLE;
            end
            PH_HDR2:
            begin
                phase_next = (rx_byte == direction_byte_reg) ? PH_DIR : PH_IDLE;
            end
            PH_DIR:
            begin
                expected_next = rx_byte;
                taken_next    = 8'd0;
                xor_next      = rx_byte;
                phase_next    = PH_LEN;
            end
            PH_LEN:
            begin
                xor_next               = xor_reg ^ rx_byte;
                command_next           = rx_byte;
                phase_next             = PH_PAYLOAD;
                push.valid             = 1'b1;
                push.res.frame_command = rx_byte;
            end
            PH_PAYLOAD:
            begin
                push.valid = 1'b1;
                if (taken_reg < expected_reg)
                begin
                    xor_next      = xor_reg ^ rx_byte;
                    taken_next    = taken_reg + 8'd1;
                    push.res.kind = mfr_pkg::KIND_PAYLOAD;
                end
                else
                begin
                    phase_next          = PH_IDLE;
                    push.res.kind       = (xor_reg == rx_byte) ? mfr_pkg::KIND_GOOD
                                                               : mfr_pkg::KIND_BAD;
                    push.res.frame_last = 1'b1;
                end
            end
            default:
            begin
                phase_next = (rx_byte == header_first_reg) ? PH_HDR1 : PH_IDLE;
            end
        endcase
        push.valid = push.valid & accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            xor_reg      <= 8'd0;
            expected_reg <= 8'd0;
            taken_reg    <= 8'd0;
            command_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            xor_reg      <= xor_next;
            expected_reg <= expected_next;
            taken_reg    <= taken_next;
            command_reg  <= command_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/mfr_queue.sv =====
// short result queue between the parser and the output stage
// depends on mfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mfr_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mfr_pkg::push_t push,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output mfr_pkg::res_t      pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfr_pkg::res_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push.valid && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on pop");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with diverged pointers");
`endif

endmodule

`default_nettype wire

// ===== design/mfr_out_stage.sv =====
// back end: output register driving the master stream
// depends on mfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mfr_out_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire mfr_pkg::res_t q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    logic          valid_reg;
    mfr_pkg::res_t data_reg;

    assign q_pop = !q_empty && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || m_tready)
        begin
            valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= q_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.payload_length, data_reg.frame_command, data_reg.data_byte};
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.frame_last;

endmodule

`default_nettype wire

// ===== design/msp_frame_receiver.sv =====
// serial frame receiver top level: parser, result queue, output stage
// depends on mfr_pkg, mfr_parser, mfr_queue, mfr_out_stage
// a byte that yields a result is written into the queue, then into the output register that drives m_tvalid
// throughput: one byte per cycle while the queue is not full; s_tready drops when it fills
// header and length bytes yield no result
// reset: rst_n clears the parse state, queue and output valid flag and restores the default header bytes
`timescale 1ns / 1ps
`default_nettype none

module msp_frame_receiver #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // data_byte, frame_command, payload_length
    output logic [1:0]       m_tuser,     // kind
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    mfr_pkg::push_t push;
    mfr_pkg::res_t  q_data;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           accept;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    mfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    mfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_data (q_data)
    );

    mfr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_msp_frame_receiver.sv =====
// testbench for msp_frame_receiver: streams framed and corrupted serial bytes, predicts
// every command, payload and end-of-frame result and checks them in order
// depends on mfr_pkg and the msp_frame_receiver rtl
`timescale 1ns / 1ps

module tb_msp_frame_receiver;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 340;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_HDR1 = 3'd1,
        ST_HDR2 = 3'd2,
        ST_DIR  = 3'd3,
        ST_LEN  = 3'd4,
        ST_BODY = 3'd5
    } parse_st_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;      // data_byte, frame_command, payload_length
    logic [1:0]  m_tuser;      // kind
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    logic [7:0]     rx_stream_q[$];
    mfr_pkg::res_t  frame_results_q[$];
    bit         offering = 1'b0;
    int         pushed_items = 0;
    int         send_idle_pct = 29;
    int         recv_idle_pct = 45;
    int         hold_reqs = 0;
    int         hold_done = 0;
    int         hold_left = 0;
    int         quiet_cycles = 0;
    int         err_cnt = 0;

    // predictor copy of configuration and parse state
    logic [7:0] exp_hdr_first  = mfr_pkg::RST_HEADER_FIRST;
    logic [7:0] exp_hdr_second = mfr_pkg::RST_HEADER_SECOND;
    logic [7:0] exp_dir_byte   = mfr_pkg::RST_DIRECTION_BYTE;
    parse_st_t  prs_state = ST_IDLE;
    logic [7:0] chk_acc = 8'h00;
    logic [8:0] len_want = 9'd0;
    logic [8:0] len_got = 9'd0;
    logic [7:0] cmd_cur = 8'h00;

    msp_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void deframe_byte(input logic [7:0] b);
        mfr_pkg::res_t r;
        bit   emit;
        r = '0;
        emit = 1'b0;
        case (prs_state)
            ST_HDR1: prs_state = (b == exp_hdr_second) ? ST_HDR2 : ST_IDLE;
            ST_HDR2: prs_state = (b == exp_dir_byte) ? ST_DIR : ST_IDLE;
            ST_DIR:
            begin
                len_want = {1'b0, b};
                len_got = 9'd0;
                chk_acc = b;
                prs_state = ST_LEN;
            end
            ST_LEN:
            begin
                chk_acc = chk_acc ^ b;
                cmd_cur = b;
                prs_state = ST_BODY;
                emit = 1'b1;
                r.kind = mfr_pkg::KIND_COMMAND;
            end
            ST_BODY:
            begin
                emit = 1'b1;
                if (len_got < len_want)
                begin
                    chk_acc = chk_acc ^ b;
                    len_got = len_got + 9'd1;
                    r.kind = mfr_pkg::KIND_PAYLOAD;
                end
                else
                begin
                    prs_state = ST_IDLE;
                    r.kind = (chk_acc == b) ? mfr_pkg::KIND_GOOD : mfr_pkg::KIND_BAD;
                    r.frame_last = 1'b1;
                end
            end
            default: prs_state = (b == exp_hdr_first) ? ST_HDR1 : ST_IDLE;
        endcase
        if (emit)
        begin
            r.data_byte = b;
            r.frame_command = cmd_cur;
            r.payload_length = len_want[7:0];
            frame_results_q.push_back(r);
        end
    endfunction

    // input side: transaction bookkeeping and prediction
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            deframe_byte(s_tdata);
            void'(rx_stream_q.pop_front());
            offering = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !offering)
        begin
            if (rx_stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tdata <= rx_stream_q[0];
                s_tvalid <= 1'b1;
                offering = 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready with a single long hold-off
    always @(negedge clk)
    begin
        if (hold_reqs != hold_done)
        begin
            hold_done = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        mfr_pkg::res_t got;
        mfr_pkg::res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.data_byte = m_tdata[7:0];
            got.frame_command = m_tdata[15:8];
            got.payload_length = m_tdata[23:16];
            got.frame_last = m_tlast;
            if (frame_results_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result: kind %0d data %02h cmd %02h len %0d last %0b",
                             got.kind, got.data_byte, got.frame_command,
                             got.payload_length, got.frame_last);
            end
            else
            begin
                want = frame_results_q.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                    got.frame_command !== want.frame_command ||
                    got.payload_length !== want.payload_length ||
                    got.frame_last !== want.frame_last)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"mismatch: expected kind %0d data %02h cmd %02h len %0d ",
                                  "last %0b, got kind %0d data %02h cmd %02h len %0d last %0b"},
                                 want.kind, want.data_byte, want.frame_command,
                                 want.payload_length, want.frame_last,
                                 got.kind, got.data_byte, got.frame_command,
                                 got.payload_length, got.frame_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        rx_stream_q.push_back(b);
        pushed_items++;
    endtask

    task automatic queue_frame(input logic [7:0] len, input logic [7:0] cmd, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] pb;
        queue_byte(exp_hdr_first);
        queue_byte(exp_hdr_second);
        queue_byte(exp_dir_byte);
        queue_byte(len);
        queue_byte(cmd);
        sum = len ^ cmd;
        for (int i = 0; i < len; i++)
        begin
            pb = 8'($urandom);
            sum = sum ^ pb;
            queue_byte(pb);
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        queue_byte(sum);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            mfr_pkg::CFG_HEADER_FIRST:   exp_hdr_first = val;
            mfr_pkg::CFG_HEADER_SECOND:  exp_hdr_second = val;
            mfr_pkg::CFG_DIRECTION_BYTE: exp_dir_byte = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        wait (rx_stream_q.size() == 0 && !offering && frame_results_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_traffic(input int n);
        int         first;
        int         sel;
        logic [7:0] b;
        first = pushed_items;
        while (pushed_items - first < n)
        begin
            sel = $urandom_range(99);
            if (sel < 77)
            begin
                // well-formed frames, some with a corrupted checksum
                if ($urandom_range(9) == 0)
                    queue_frame(8'($urandom_range(16, 48)), 8'($urandom), sel >= 65);
                else
                    queue_frame(8'($urandom_range(0, 6)), 8'($urandom), sel >= 65);
            end
            else if (sel < 89)
            begin
                // header broken on the second or direction byte
                queue_byte(exp_hdr_first);
                if ($urandom_range(1) == 0)
                begin
                    b = 8'($urandom);
                    queue_byte((b == exp_hdr_second) ? ~b : b);
                end
                else
                begin
                    queue_byte(exp_hdr_second);
                    b = 8'($urandom);
                    queue_byte((b == exp_dir_byte) ? ~b : b);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = mfr_pkg::CFG_HEADER_FIRST;
        cfg_data = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero length, max command with bad checksum, header mismatches
        queue_frame(8'h00, 8'h00, 1'b0);
        queue_frame(8'd2, 8'hff, 1'b1);
        queue_byte(exp_hdr_first);
        queue_byte(exp_hdr_first);
        queue_byte(exp_hdr_second);
        queue_byte(exp_hdr_first);
        queue_byte(exp_hdr_second);
        queue_byte(~exp_dir_byte);
        queue_byte(8'hff);
        queue_frame(8'd1, 8'h80, 1'b0);
        wait_drained();

        cfg_write(mfr_pkg::CFG_HEADER_FIRST, 8'h00);
        cfg_write(mfr_pkg::CFG_HEADER_SECOND, 8'hff);
        cfg_write(mfr_pkg::CFG_DIRECTION_BYTE, 8'h00);
        cfg_write(CFG_UNUSED, 8'($urandom));
        random_traffic(PHASE_ITEMS);
        hold_reqs++;
        wait_drained();

        send_idle_pct = 45;
        recv_idle_pct = 29;
        cfg_write(mfr_pkg::CFG_HEADER_FIRST, 8'hff);
        cfg_write(mfr_pkg::CFG_HEADER_SECOND, 8'h00);
        cfg_write(mfr_pkg::CFG_DIRECTION_BYTE, 8'hff);
        random_traffic(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_write(mfr_pkg::CFG_HEADER_FIRST, 8'($urandom));
        cfg_write(mfr_pkg::CFG_HEADER_SECOND, 8'($urandom));
        cfg_write(mfr_pkg::CFG_DIRECTION_BYTE, 8'($urandom));
        queue_frame(8'hff, 8'($urandom), 1'b0);
        random_traffic(PHASE_ITEMS);
        wait_drained();

        if (err_cnt == 0 && frame_results_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
